// ----- rtl/hcs_pkg.sv -----
// ----------------------------------------------------------------------------
// hcs_pkg: shared types and constants for the contrast stretch unit
// Field widths, function codes, register indexes and the control and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package hcs_pkg;

  localparam int PIX_W          = 8;
  localparam int FUNC_W         = 2;
  localparam int OUT_COUNT_W    = 17;
  localparam int NUM_BINS       = 256;
  localparam int BIN_AW         = 8;
  localparam int CFG_W          = 8;
  localparam int REG_IDX_W      = 1;
  localparam int COUNT_BITS_DEF = 17;
  localparam int DIV_STEPS      = 8;
  localparam int STEP_W         = 3;

  localparam logic [PIX_W-1:0] FULL_SCALE = 8'd255;

  localparam logic [REG_IDX_W-1:0] REG_MIN_LEVEL = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_MAX_LEVEL = 1'b1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PIXEL = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NONE  = 2'd3
  } hcs_func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_DIVIDE,
    ST_FINISH
  } hcs_state_t;

  // controller to datapath
  typedef struct packed {
    logic in_ready;
    logic accept;
    logic lookup;
    logic div_step;
    logic load;
  } hcs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_pixel;
    logic need_div;
    logic div_last;
    logic out_free;
  } hcs_stat_t;

endpackage

// ----- rtl/hcs_if.sv -----
// ----------------------------------------------------------------------------
// hcs_if: request and result channels of the contrast stretch unit
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface hcs_in_if import hcs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [PIX_W-1:0]  value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface hcs_out_if import hcs_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [PIX_W-1:0]       pixel_out;
  logic [OUT_COUNT_W-1:0] bin_count;

  modport source (output valid, output pixel_out, output bin_count, input ready);
  modport sink   (input valid, input pixel_out, input bin_count, output ready);
endinterface

// ----- rtl/hcs_ram.sv -----
// ----------------------------------------------------------------------------
// hcs_ram: generic single-write, single-read memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module hcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/hcs_ctrl.sv -----
// ----------------------------------------------------------------------------
// hcs_ctrl: item sequencer
// Steps each item through lookup, optional division and result hand-off.
// ----------------------------------------------------------------------------
module hcs_ctrl import hcs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  input  hcs_stat_t stat,
  output hcs_cmd_t  cmd
);

  hcs_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) state_next = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        state_next = (stat.is_pixel && stat.need_div) ? ST_DIVIDE : ST_FINISH;
      end
      ST_DIVIDE: begin
        if (stat.div_last) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.accept   = req_valid;
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
      end
      ST_FINISH: begin
        cmd.load = stat.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ----- rtl/hcs_datapath.sv -----
// ----------------------------------------------------------------------------
// hcs_datapath: histogram store, stretch divider and result register
// Holds the level registers, bin memory with valid bits, a restoring
// divider producing one quotient bit per step, and the output register.
// ----------------------------------------------------------------------------
module hcs_datapath import hcs_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [REG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic [FUNC_W-1:0]      req_func,
  input  logic [PIX_W-1:0]       req_value,
  input  hcs_cmd_t               cmd,
  output hcs_stat_t              stat,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [PIX_W-1:0]       pixel_out,
  output logic [OUT_COUNT_W-1:0] bin_count
);

  logic [PIX_W-1:0]      min_level, max_level;
  hcs_func_t             func_q;
  logic [BIN_AW-1:0]     value_q;
  logic [NUM_BINS-1:0]   bin_valid;
  logic [COUNT_BITS-1:0] ram_rdata, cur_count, inc_count, count;
  logic                  ram_we;
  logic [PIX_W-1:0]      pix, rem, num_lo, dvsr, diff;
  logic [2*PIX_W-1:0]    prod;
  logic [PIX_W:0]        trial;
  logic                  trial_ge;
  logic [STEP_W-1:0]     step;
  logic                  range_ok, above_min, at_max;

  // level registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_level <= '0;
      max_level <= FULL_SCALE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_LEVEL: min_level <= cfg_data;
        REG_MAX_LEVEL: max_level <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_q  <= hcs_func_t'(req_func);
      value_q <= req_value;
    end
  end

  // bin store: read issued at accept, data ready in lookup
  assign ram_we = cmd.lookup && (func_q == FUNC_PIXEL);

  hcs_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (NUM_BINS)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (value_q),
    .wdata (inc_count),
    .raddr (req_value),
    .rdata (ram_rdata)
  );

  assign cur_count = bin_valid[value_q] ? ram_rdata : '0;
  assign inc_count = (cur_count == {COUNT_BITS{1'b1}}) ? cur_count
                                                       : cur_count + COUNT_BITS'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_valid <= '0;
    end else if (cmd.lookup && func_q == FUNC_CLEAR) begin
      bin_valid <= '0;
    end else if (ram_we) begin
      bin_valid[value_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      count <= (func_q == FUNC_READ) ? cur_count : '0;
    end
  end

  // stretch classification
  assign range_ok  = max_level > min_level;
  assign above_min = value_q > min_level;
  assign at_max    = value_q >= max_level;
  assign diff      = value_q - min_level;
  assign prod      = {diff, {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, diff};

  // restoring divider, quotient shifts into pix
  assign trial    = {rem, num_lo[PIX_W-1]};
  assign trial_ge = trial >= {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      rem    <= prod[2*PIX_W-1:PIX_W];
      num_lo <= prod[PIX_W-1:0];
      dvsr   <= max_level - min_level;
      step   <= '0;
      pix    <= (func_q == FUNC_PIXEL && range_ok && at_max) ? FULL_SCALE : '0;
    end else if (cmd.div_step) begin
      rem    <= trial_ge ? PIX_W'(trial - {1'b0, dvsr}) : trial[PIX_W-1:0];
      num_lo <= {num_lo[PIX_W-2:0], 1'b0};
      pix    <= {pix[PIX_W-2:0], trial_ge};
      step   <= step + STEP_W'(1);
    end
  end

  assign stat.is_pixel = (func_q == FUNC_PIXEL);
  assign stat.need_div = range_ok && above_min && !at_max;
  assign stat.div_last = (step == STEP_W'(DIV_STEPS - 1));
  assign stat.out_free = !out_valid || out_ready;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pixel_out <= pix;
    end
  end

  generate
    if (COUNT_BITS >= OUT_COUNT_W) begin : g_count_trunc
      always_ff @(posedge clk) begin
        if (cmd.load) bin_count <= count[OUT_COUNT_W-1:0];
      end
    end else begin : g_count_ext
      always_ff @(posedge clk) begin
        if (cmd.load) bin_count <= {{(OUT_COUNT_W-COUNT_BITS){1'b0}}, count};
      end
    end
  endgenerate

endmodule

// ----- rtl/histogram_contrast_stretch_unit.sv -----
// ----------------------------------------------------------------------------
// histogram_contrast_stretch_unit: grey-level contrast stretch with histogram
// Stretches 8-bit pixels between configured min and max levels, keeps a
// 256-bin saturating histogram, and serves bin reads and histogram clears.
//
//   channel  dir  beat contents               accepted when
//   req      in   func, value                 req.valid && req.ready
//   rsp      out  pixel_out, bin_count        rsp.valid && rsp.ready
//   cfg      in   cfg_index, cfg_data         cfg_we
//
// sequencing: reads, clears and pixels outside the open range skip the divider;
// a pixel that needs the quotient passes through the restoring divider
// (one quotient bit a cycle, 8 steps) after the bin memory's registered read
// reset: rst clears the sequencer, the result register and all bin valid bits
// at once, so the histogram reads as zero right after reset with no sweep
// stalls: a finished result sits in the output register; the next item is
// taken while it waits and only its hand-off waits for rsp.ready
// ----------------------------------------------------------------------------
module histogram_contrast_stretch_unit import hcs_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  hcs_in_if.sink               req,
  hcs_out_if.source            rsp
);

  hcs_cmd_t  cmd;
  hcs_stat_t stat;

  // sequencer: idle, lookup, divide, finish
  hcs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  // request beat taken only when the sequencer is idle
  assign req.ready = cmd.in_ready;

  // datapath: level registers, bin store, divider, result register
  hcs_datapath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_func  (req.func),
    .req_value (req.value),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (rsp.ready),
    .out_valid (rsp.valid),
    .pixel_out (rsp.pixel_out),
    .bin_count (rsp.bin_count)
  );

  // block is busy right after taking a beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> !req.ready)
    else $error("request taken while previous item in progress");

  // every load shows up as a valid result
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> rsp.valid)
    else $error("loaded result not presented");

  // a result never appears without a load
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(cmd.load))
    else $error("result appeared without a load");

  // non-pixel items carry a zero pixel
  a_pixel_zero: assert property (@(posedge clk) disable iff (rst)
    (cmd.load && !stat.is_pixel) |=> (rsp.pixel_out == '0))
    else $error("non-pixel result has nonzero pixel");

endmodule
